// ===== src/amf_pkg.sv =====
// ----------------------------------------------------------------------------
// amf_pkg
// Shared types and constants of the addressed message framer.
// ----------------------------------------------------------------------------
package amf_pkg;

	localparam int MAX_TEXT_CHARS = 8;
	localparam int TEXT_W         = 8 * MAX_TEXT_CHARS;
	localparam int NUM_W          = 32;
	localparam int DIGITS         = 10;
	localparam int BCD_W          = 4 * DIGITS;
	localparam int DABBLE_STEPS   = 8;
	localparam int DABBLE_STAGES  = NUM_W / DABBLE_STEPS;
	localparam int PAY_MAX        = DIGITS;
	localparam int CNT_W          = 4;
	localparam int IN_W           = 128;

	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_DEC3  = 3'd1,
		CMD_DEC5  = 3'd2,
		CMD_DEC10 = 3'd3,
		CMD_TEXT  = 3'd4
	} cmd_t;

	// one request on its way through the conversion pipeline
	typedef struct packed {
		cmd_t                    cmd;
		logic [7:0]              addr;
		logic [7:0]              char0;
		logic [7:0]              char1;
		logic [NUM_W-1:0]        bin;
		logic [BCD_W-1:0]        bcd;
		logic [TEXT_W-1:0]       text;
		logic [CNT_W-1:0]        text_len;
	} frame_t;

endpackage

// ===== src/amf_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// amf_dabble_stage
// One pipeline stage of the binary to BCD converter: eight shift-and-add-3
// steps, registered, with valid/ready flow control.
// ----------------------------------------------------------------------------
module amf_dabble_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  amf_pkg::frame_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output amf_pkg::frame_t   out_data
);

	logic            valid_q;
	amf_pkg::frame_t data_q;
	amf_pkg::frame_t next_data;
	logic            advance;

	assign advance  = !valid_q || out_ready;
	assign in_ready = advance;

	always_comb begin
		logic [amf_pkg::BCD_W-1:0] bcd;
		logic [amf_pkg::NUM_W-1:0] bin;
		bcd       = in_data.bcd;
		bin       = in_data.bin;
		next_data = in_data;
		for (int k = 0; k < amf_pkg::DABBLE_STEPS; k++) begin
			for (int d = 0; d < amf_pkg::DIGITS; d++) begin
				if (bcd[4*d +: 4] >= 4'd5) begin
					bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
				end
			end
			bcd = {bcd[amf_pkg::BCD_W-2:0], bin[amf_pkg::NUM_W-1]};
			bin = {bin[amf_pkg::NUM_W-2:0], 1'b0};
		end
		next_data.bcd = bcd;
		next_data.bin = bin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== src/amf_serializer.sv =====
// ----------------------------------------------------------------------------
// amf_serializer
// Lays out one converted request as a frame and sends it one symbol per
// cycle while out_ready does not stall it, through a registered output.
// ----------------------------------------------------------------------------
module amf_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  amf_pkg::frame_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_symbol,
	output logic              out_mark,
	output logic              out_last
);

	logic [amf_pkg::BCD_W-1:0]        aligned;
	logic [7:0]                       pay_next [amf_pkg::PAY_MAX];
	logic [amf_pkg::CNT_W-1:0]        plen_next;

	logic                             frame_v_q;
	logic [7:0]                       addr_q;
	logic [7:0]                       char0_q;
	logic [7:0]                       char1_q;
	logic [7:0]                       pay_q [amf_pkg::PAY_MAX];
	logic [amf_pkg::CNT_W-1:0]        last_idx_q;
	logic [amf_pkg::CNT_W-1:0]        idx_q;
	logic [amf_pkg::CNT_W-1:0]        pidx;

	logic                             out_v_q;
	logic [7:0]                       sym_q;
	logic                             mark_q;
	logic                             last_q;

	logic                             issue;
	logic                             is_last;
	logic [7:0]                       sym;

	// digits come out most significant first: push the wanted digits to the top
	always_comb begin
		aligned   = in_data.bcd;
		plen_next = '0;
		unique case (in_data.cmd)
			amf_pkg::CMD_DEC3: begin
				aligned   = in_data.bcd << (4 * (amf_pkg::DIGITS - 3));
				plen_next = amf_pkg::CNT_W'(3);
			end
			amf_pkg::CMD_DEC5: begin
				aligned   = in_data.bcd << (4 * (amf_pkg::DIGITS - 5));
				plen_next = amf_pkg::CNT_W'(5);
			end
			amf_pkg::CMD_DEC10: begin
				plen_next = amf_pkg::CNT_W'(amf_pkg::DIGITS);
			end
			amf_pkg::CMD_TEXT: begin
				plen_next = in_data.text_len;
			end
			default: begin
				plen_next = '0;
			end
		endcase
	end

	always_comb begin
		for (int p = 0; p < amf_pkg::PAY_MAX; p++) begin
			pay_next[p] = amf_pkg::ASCII_ZERO
				+ {4'b0000, aligned[4*(amf_pkg::DIGITS-1-p) +: 4]};
		end
		if (in_data.cmd == amf_pkg::CMD_TEXT) begin
			for (int p = 0; p < amf_pkg::PAY_MAX; p++) begin
				pay_next[p] = 8'h00;
			end
			for (int p = 0; p < amf_pkg::MAX_TEXT_CHARS; p++) begin
				pay_next[p] = in_data.text[8*p +: 8];
			end
		end
	end

	assign issue    = frame_v_q && (!out_v_q || out_ready);
	assign is_last  = (idx_q == last_idx_q);
	assign in_ready = !frame_v_q || (issue && is_last);
	assign pidx     = idx_q - amf_pkg::CNT_W'(3);

	always_comb begin
		priority if (idx_q == amf_pkg::CNT_W'(0)) begin
			sym = addr_q;
		end else if (idx_q == amf_pkg::CNT_W'(1)) begin
			sym = char0_q;
		end else if (idx_q == amf_pkg::CNT_W'(2)) begin
			sym = char1_q;
		end else if (is_last) begin
			sym = amf_pkg::ASCII_NEWLINE;
		end else if (pidx < amf_pkg::CNT_W'(amf_pkg::PAY_MAX)) begin
			sym = pay_q[pidx];
		end else begin
			sym = amf_pkg::ASCII_NEWLINE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_q <= 1'b0;
			idx_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (in_ready && in_valid) begin
				frame_v_q <= 1'b1;
				idx_q     <= '0;
			end else if (issue && is_last) begin
				frame_v_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + amf_pkg::CNT_W'(1);
			end
			if (issue) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			addr_q     <= in_data.addr;
			char0_q    <= in_data.char0;
			char1_q    <= in_data.char1;
			pay_q      <= pay_next;
			last_idx_q <= plen_next + amf_pkg::CNT_W'(3);
		end
		if (issue) begin
			sym_q  <= sym;
			mark_q <= (idx_q == amf_pkg::CNT_W'(0));
			last_q <= is_last;
		end
	end

	assign out_valid  = out_v_q;
	assign out_symbol = sym_q;
	assign out_mark   = mark_q;
	assign out_last   = last_q;

	a_mark_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && mark_q |-> !last_q)
		else $error("address symbol flagged last");

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_v_q |-> idx_q <= last_idx_q)
		else $error("symbol index beyond frame end");

	a_first_marked: assert property (@(posedge clk) disable iff (!arst_n)
		issue && idx_q == amf_pkg::CNT_W'(0) |=> out_v_q && mark_q)
		else $error("first symbol lost its address mark");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		issue && is_last |=> out_v_q && last_q && sym_q == amf_pkg::ASCII_NEWLINE)
		else $error("frame not closed by a newline");

endmodule

// ===== src/addressed_message_framer.sv =====
// Path: a request passes the input register, the four conversion stages and the serializer's
// frame and output registers; then one symbol per cycle while m_tready is high.
// Throughput: a frame of 4 to 14 symbols leaves at one symbol per cycle while m_tready is high;
// the serializer takes the next request as the last symbol leaves, so it sets the request rate.
// Conversion: four register stages of eight binary-to-BCD steps each.
// Reset: arst_n clears the valid flags and the serializer's symbol index; no frame is in flight after reset.
// ----------------------------------------------------------------------------
// addressed_message_framer
// Builds 9-bit multidrop frames: address, two characters, decimal or text
// payload, newline.
// ----------------------------------------------------------------------------
module addressed_message_framer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[2:0], slave_address[10:3], first_char[18:11], second_char[26:19],
	// number[58:27], text_lower[90:59], text_upper[122:91], zero fill
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,  // symbol[7:0]
	output logic         m_tuser,  // address_mark
	output logic         m_tlast
);

	localparam int NS = amf_pkg::DABBLE_STAGES;

	logic                 v_s1;
	amf_pkg::frame_t      d_s1;
	amf_pkg::frame_t      d_next;
	logic                 adv_s1;

	logic                 st_valid [NS+1];
	logic                 st_ready [NS+1];
	amf_pkg::frame_t      st_data  [NS+1];

	always_comb begin
		logic [amf_pkg::TEXT_W-1:0] text;
		logic                       stop;
		logic [amf_pkg::CNT_W-1:0]  len;
		text = {s_tdata[122:91], s_tdata[90:59]};
		stop = 1'b0;
		len  = '0;
		for (int i = 0; i < amf_pkg::MAX_TEXT_CHARS; i++) begin
			if (text[8*i +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				len = len + amf_pkg::CNT_W'(1);
			end
		end
		d_next.cmd      = amf_pkg::cmd_t'(s_tdata[2:0]);
		d_next.addr     = s_tdata[10:3];
		d_next.char0    = s_tdata[18:11];
		d_next.char1    = s_tdata[26:19];
		d_next.bcd      = '0;
		d_next.text     = text;
		d_next.text_len = len;
		unique case (amf_pkg::cmd_t'(s_tdata[2:0]))
			amf_pkg::CMD_DEC3:  d_next.bin = {24'h000000, s_tdata[34:27]};
			amf_pkg::CMD_DEC5:  d_next.bin = {16'h0000, s_tdata[42:27]};
			default:            d_next.bin = s_tdata[58:27];
		endcase
	end

	assign adv_s1   = !v_s1 || st_ready[0];
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			d_s1 <= d_next;
		end
	end

	assign st_valid[0] = v_s1;
	assign st_data[0]  = d_s1;

	for (genvar g = 0; g < NS; g++) begin : g_dabble
		amf_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[g]),
			.in_ready  (st_ready[g]),
			.in_data   (st_data[g]),
			.out_valid (st_valid[g+1]),
			.out_ready (st_ready[g+1]),
			.out_data  (st_data[g+1])
		);
	end

	amf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (st_valid[NS]),
		.in_ready   (st_ready[NS]),
		.in_data    (st_data[NS]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_symbol (m_tdata),
		.out_mark   (m_tuser),
		.out_last   (m_tlast)
	);

endmodule
